// File: sv/gob_pkg.sv
// Shared constants, codes and types of the grid occupancy bitmap.
package gob_pkg;

	localparam int ROWS          = 512;
	localparam int WORDS_PER_ROW = 8;
	localparam int DEPTH         = ROWS * WORDS_PER_ROW;
	localparam int ADDR_W        = $clog2(DEPTH);
	localparam int ROW_W         = $clog2(ROWS);
	localparam int NCELLS        = 64 * WORDS_PER_ROW;
	localparam int CELL_W        = $clog2(NCELLS);
	localparam int WORD_W        = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
	localparam int CFG_W         = 32;

	localparam logic [2:0] CMD_CHECK       = 3'd0;
	localparam logic [2:0] CMD_SET_POINT   = 3'd1;
	localparam logic [2:0] CMD_CLEAR_POINT = 3'd2;
	localparam logic [2:0] CMD_SET_SPAN    = 3'd3;
	localparam logic [2:0] CMD_CLEAR_SPAN  = 3'd4;
	localparam logic [2:0] CMD_CLEAR_ALL   = 3'd5;

	localparam logic [2:0] REG_RANGE_MIN_X    = 3'd0;
	localparam logic [2:0] REG_RANGE_MIN_Y    = 3'd1;
	localparam logic [2:0] REG_RANGE_MAX_X    = 3'd2;
	localparam logic [2:0] REG_RANGE_MAX_Y    = 3'd3;
	localparam logic [2:0] REG_INVERSE_CELL_X = 3'd4;
	localparam logic [2:0] REG_INVERSE_CELL_Y = 3'd5;
	localparam logic [2:0] REG_MAJOR_AXIS     = 3'd6;

	localparam logic signed [31:0] RST_RANGE_MIN = 32'sd0;
	localparam logic signed [31:0] RST_RANGE_MAX = 32'sd131072;
	localparam logic [23:0]        RST_INV_CELL  = 24'd65536;

	typedef logic [1:0] tag_t;

	localparam tag_t TAG_MAJOR = 2'd0;
	localparam tag_t TAG_LO    = 2'd1;
	localparam tag_t TAG_HI    = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_EVAL,
		ST_READ,
		ST_MODIFY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               valid;
		tag_t               tag;
		logic signed [31:0] pos;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [23:0]        inv;
	} cell_req_t;

	typedef struct packed {
		logic        valid;
		tag_t        tag;
		logic        inb;
		logic [31:0] cell_idx;
	} cell_rsp_t;

endpackage

// File: sv/gob_cell_unit.sv
// Two-stage pipeline that bounds-checks a coordinate and quantizes it to a cell index.
module gob_cell_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  gob_pkg::cell_req_t req,
	output gob_pkg::cell_rsp_t rsp
);

	logic              v_s1;
	logic              v_s2;
	gob_pkg::tag_t     tag_s1;
	gob_pkg::tag_t     tag_s2;
	logic [32:0]       diff_s1;
	logic [23:0]       inv_s1;
	logic              inb_s1;
	logic              inb_s2;
	logic [31:0]       cell_s2;
	logic [55:0]       prod;

	assign prod = 56'(diff_s1[31:0]) * 56'(inv_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= req.tag;
		diff_s1 <= {req.pos[31], req.pos} - {req.lo[31], req.lo};
		inv_s1  <= req.inv;
		inb_s1  <= (req.pos >= req.lo) && (req.pos < req.hi);
		tag_s2  <= tag_s1;
		inb_s2  <= inb_s1;
		cell_s2 <= diff_s1[32] ? 32'd0 : prod[55:24];
	end

	assign rsp.valid    = v_s2;
	assign rsp.tag      = tag_s2;
	assign rsp.inb      = inb_s2;
	assign rsp.cell_idx = cell_s2;

endmodule

// File: sv/grid_occupancy_bitmap_core.sv
// Top level of the grid occupancy bitmap: configuration, sequencer and word store.
//
// Usage: items arrive on the input channel (in_valid, in_stall) and each one
// yields exactly one result on the output channel (out_valid, out_stall).
// A transfer on either channel happens at a clock edge with valid high and
// stall low. The user must write configuration registers through cfg_we,
// cfg_index and cfg_data only while no item is in progress, which the block
// does not enforce. Items are handled one at a time. The shared two-stage cell
// unit (one 32 by 24 multiply) quantizes two coordinates for a point and three
// for a span, and each touched store word is read and then, but for a check,
// written back on the single-port word memory.
// After reset the store is swept to zero, one word a cycle over all DEPTH words
// (4096 at the default size), while in_stall stays high.
// The result sits in an output register; a new item can be taken while it
// waits, and the next result waits until the receiver lowers out_stall.
module grid_occupancy_bitmap_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] span_major,
	input  logic signed [31:0] span_min,
	input  logic signed [31:0] span_max,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        bit_value,
	output logic        inside_res
);

	logic signed [31:0] range_min_x_q;
	logic signed [31:0] range_min_y_q;
	logic signed [31:0] range_max_x_q;
	logic signed [31:0] range_max_y_q;
	logic [23:0]        inverse_cell_x_q;
	logic [23:0]        inverse_cell_y_q;
	logic               major_axis_q;

	gob_pkg::state_t    state_q;
	gob_pkg::state_t    state_d;
	logic [gob_pkg::ADDR_W-1:0] clr_q;
	logic               clr_cmd_q;
	logic [2:0]         cmd_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic signed [31:0] span_major_q;
	logic signed [31:0] span_min_q;
	logic signed [31:0] span_max_q;
	gob_pkg::tag_t      iss_q;
	logic [31:0]        cell_maj_q;
	logic [31:0]        cell_a_q;
	logic [31:0]        cell_b_q;
	logic               inb0_q;
	logic               inb1_q;
	logic [gob_pkg::ROW_W-1:0]  row_q;
	logic [gob_pkg::CELL_W-1:0] lo_q;
	logic [gob_pkg::CELL_W-1:0] hi_q;
	logic [gob_pkg::WORD_W-1:0] w_q;
	logic               res_bit_q;
	logic               res_inside_q;
	logic               out_valid_q;
	logic               bit_value_q;
	logic               inside_res_q;
	logic [63:0]        rd_q;
	logic [63:0]        mem [gob_pkg::DEPTH];

	logic               is_point;
	logic               is_check;
	gob_pkg::tag_t      last_tag;
	logic               issue;
	logic               axis;
	logic signed [31:0] iss_pos;
	gob_pkg::cell_req_t req;
	gob_pkg::cell_rsp_t rsp;
	logic               in_take;
	logic               out_free;
	logic               out_load;
	logic               calc_end;
	logic               eval_inside;
	logic               eval_go;
	logic [gob_pkg::CELL_W-1:0] lo_sat;
	logic [gob_pkg::CELL_W-1:0] hi_sat;
	logic [gob_pkg::CELL_W-1:0] lo_next;
	logic [gob_pkg::CELL_W-1:0] hi_next;
	logic [gob_pkg::WORD_W-1:0] lo_word;
	logic [gob_pkg::WORD_W-1:0] hi_word;
	logic               walk_end;
	logic [gob_pkg::ADDR_W-1:0] addr;
	logic [5:0]         mask_a;
	logic [5:0]         mask_b;
	logic [63:0]        mask;
	logic               mem_we;
	logic               mem_re;
	logic [gob_pkg::ADDR_W-1:0] mem_waddr;
	logic [63:0]        mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_x_q    <= gob_pkg::RST_RANGE_MIN;
			range_min_y_q    <= gob_pkg::RST_RANGE_MIN;
			range_max_x_q    <= gob_pkg::RST_RANGE_MAX;
			range_max_y_q    <= gob_pkg::RST_RANGE_MAX;
			inverse_cell_x_q <= gob_pkg::RST_INV_CELL;
			inverse_cell_y_q <= gob_pkg::RST_INV_CELL;
			major_axis_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				gob_pkg::REG_RANGE_MIN_X:    range_min_x_q    <= cfg_data;
				gob_pkg::REG_RANGE_MIN_Y:    range_min_y_q    <= cfg_data;
				gob_pkg::REG_RANGE_MAX_X:    range_max_x_q    <= cfg_data;
				gob_pkg::REG_RANGE_MAX_Y:    range_max_y_q    <= cfg_data;
				gob_pkg::REG_INVERSE_CELL_X: inverse_cell_x_q <= cfg_data[23:0];
				gob_pkg::REG_INVERSE_CELL_Y: inverse_cell_y_q <= cfg_data[23:0];
				gob_pkg::REG_MAJOR_AXIS:     major_axis_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign is_point = cmd_q inside {gob_pkg::CMD_CHECK, gob_pkg::CMD_SET_POINT,
		gob_pkg::CMD_CLEAR_POINT};
	assign is_check = (cmd_q == gob_pkg::CMD_CHECK);
	assign last_tag = is_point ? gob_pkg::TAG_LO : gob_pkg::TAG_HI;

	always_comb begin
		axis = (iss_q == gob_pkg::TAG_MAJOR) ? major_axis_q : ~major_axis_q;
		case (iss_q)
			gob_pkg::TAG_MAJOR: iss_pos = is_point ? (major_axis_q ? pos_y_q : pos_x_q)
				: span_major_q;
			gob_pkg::TAG_LO:    iss_pos = is_point ? (major_axis_q ? pos_x_q : pos_y_q)
				: span_min_q;
			default:            iss_pos = span_max_q;
		endcase
		req.valid = issue;
		req.tag   = iss_q;
		req.pos   = iss_pos;
		req.lo    = axis ? range_min_y_q : range_min_x_q;
		req.hi    = axis ? range_max_y_q : range_max_x_q;
		req.inv   = axis ? inverse_cell_y_q : inverse_cell_x_q;
	end

	gob_cell_unit u_cell (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	assign calc_end = rsp.valid && (rsp.tag == last_tag);

	always_comb begin
		lo_sat = (cell_a_q >= 32'(gob_pkg::NCELLS)) ? gob_pkg::CELL_W'(gob_pkg::NCELLS - 1)
			: cell_a_q[gob_pkg::CELL_W-1:0];
		hi_sat = (cell_b_q >= 32'(gob_pkg::NCELLS)) ? gob_pkg::CELL_W'(gob_pkg::NCELLS - 1)
			: cell_b_q[gob_pkg::CELL_W-1:0];
		if (is_point) begin
			eval_inside = inb0_q && inb1_q && (cell_maj_q < 32'(gob_pkg::ROWS))
				&& (cell_a_q < 32'(gob_pkg::NCELLS));
			eval_go     = eval_inside;
			lo_next     = cell_a_q[gob_pkg::CELL_W-1:0];
			hi_next     = cell_a_q[gob_pkg::CELL_W-1:0];
		end else begin
			eval_inside = inb0_q && (cell_maj_q < 32'(gob_pkg::ROWS));
			eval_go     = eval_inside && (lo_sat <= hi_sat);
			lo_next     = lo_sat;
			hi_next     = hi_sat;
		end
	end

	assign lo_word  = gob_pkg::WORD_W'(lo_q >> 6);
	assign hi_word  = gob_pkg::WORD_W'(hi_q >> 6);
	assign walk_end = is_check || (w_q == hi_word);
	assign addr     = gob_pkg::ADDR_W'(32'(row_q) * gob_pkg::WORDS_PER_ROW + 32'(w_q));
	assign mask_a   = (w_q == lo_word) ? lo_q[5:0] : 6'd0;
	assign mask_b   = (w_q == hi_word) ? hi_q[5:0] : 6'd63;
	assign mask     = ({64{1'b1}} << mask_a) & ({64{1'b1}} >> (6'd63 - mask_b));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			gob_pkg::ST_CLEAR: begin
				if (clr_q == gob_pkg::ADDR_W'(gob_pkg::DEPTH - 1)) begin
					state_d = clr_cmd_q ? gob_pkg::ST_DONE : gob_pkg::ST_IDLE;
				end
			end
			gob_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (command inside {gob_pkg::CMD_CHECK, gob_pkg::CMD_SET_POINT,
						gob_pkg::CMD_CLEAR_POINT, gob_pkg::CMD_SET_SPAN,
						gob_pkg::CMD_CLEAR_SPAN}) begin
						state_d = gob_pkg::ST_CALC;
					end else if (command == gob_pkg::CMD_CLEAR_ALL) begin
						state_d = gob_pkg::ST_CLEAR;
					end else begin
						state_d = gob_pkg::ST_DONE;
					end
				end
			end
			gob_pkg::ST_CALC: begin
				if (calc_end) begin
					state_d = gob_pkg::ST_EVAL;
				end
			end
			gob_pkg::ST_EVAL: begin
				state_d = eval_go ? gob_pkg::ST_READ : gob_pkg::ST_DONE;
			end
			gob_pkg::ST_READ: begin
				state_d = gob_pkg::ST_MODIFY;
			end
			gob_pkg::ST_MODIFY: begin
				state_d = walk_end ? gob_pkg::ST_DONE : gob_pkg::ST_READ;
			end
			gob_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = gob_pkg::ST_IDLE;
				end
			end
			default: state_d = gob_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		in_take   = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = addr;
		mem_wdata = (cmd_q == gob_pkg::CMD_SET_POINT || cmd_q == gob_pkg::CMD_SET_SPAN)
			? (rd_q | mask) : (rd_q & ~mask);
		case (state_q)
			gob_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			gob_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				in_take  = in_valid;
			end
			gob_pkg::ST_CALC: begin
				issue = (iss_q <= last_tag);
			end
			gob_pkg::ST_READ: begin
				mem_re = 1'b1;
			end
			gob_pkg::ST_MODIFY: begin
				mem_we = !is_check;
			end
			gob_pkg::ST_DONE: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gob_pkg::ST_CLEAR;
			clr_q       <= '0;
			clr_cmd_q   <= 1'b0;
			iss_q       <= gob_pkg::TAG_MAJOR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gob_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (in_take) begin
				clr_q     <= '0;
				clr_cmd_q <= (command == gob_pkg::CMD_CLEAR_ALL);
				iss_q     <= gob_pkg::TAG_MAJOR;
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q        <= command;
			pos_x_q      <= pos_x;
			pos_y_q      <= pos_y;
			span_major_q <= span_major;
			span_min_q   <= span_min;
			span_max_q   <= span_max;
			res_bit_q    <= 1'b0;
			res_inside_q <= 1'b0;
		end
		if (rsp.valid) begin
			case (rsp.tag)
				gob_pkg::TAG_MAJOR: begin
					cell_maj_q <= rsp.cell_idx;
					inb0_q     <= rsp.inb;
				end
				gob_pkg::TAG_LO: begin
					cell_a_q <= rsp.cell_idx;
					inb1_q   <= rsp.inb;
				end
				default: cell_b_q <= rsp.cell_idx;
			endcase
		end
		if (state_q == gob_pkg::ST_EVAL) begin
			res_inside_q <= eval_inside;
			row_q        <= cell_maj_q[gob_pkg::ROW_W-1:0];
			lo_q         <= lo_next;
			hi_q         <= hi_next;
			w_q          <= gob_pkg::WORD_W'(lo_next >> 6);
		end
		if (state_q == gob_pkg::ST_MODIFY) begin
			if (is_check) begin
				res_bit_q <= rd_q[lo_q[5:0]];
			end
			w_q <= w_q + 1'b1;
		end
		if (out_load) begin
			bit_value_q  <= res_bit_q;
			inside_res_q <= res_inside_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[addr];
		end
	end

	assign out_valid  = out_valid_q;
	assign bit_value  = bit_value_q;
	assign inside_res = inside_res_q;

	a_rsp_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> state_q == gob_pkg::ST_CALC)
		else $error("cell unit response outside of the calculation phase");

	a_modify_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gob_pkg::ST_MODIFY |-> $past(state_q) == gob_pkg::ST_READ)
		else $error("store write without a preceding read");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gob_pkg::ST_MODIFY |-> w_q <= hi_word)
		else $error("span walk ran past its last word");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == gob_pkg::ST_CLEAR) |-> mem_wdata == 64'd0)
		else $error("clearing pass wrote a nonzero word");

endmodule

// File: test/tb.sv
// Self-checking testbench for the grid occupancy bitmap core, with its own bitmap predictor.
`timescale 1ns / 1ps

module tb;

	localparam logic [2:0] CMD_UNUSED_A = 3'd6;
	localparam logic [2:0] CMD_UNUSED_B = 3'd7;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [2:0]  cmd;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] span_at;
		logic [31:0] span_from;
		logic [31:0] span_to;
	} grid_op_t;

	typedef struct packed {
		logic bv;
		logic ins;
	} grid_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = '0;
	logic [31:0] pos_x = '0;
	logic [31:0] pos_y = '0;
	logic [31:0] span_major = '0;
	logic [31:0] span_min = '0;
	logic [31:0] span_max = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic        bit_value;
	logic        inside_res;

	// Predictor state: the expected store and a copy of the configuration.
	bit [63:0]         occupancy [gob_pkg::DEPTH];
	longint            range_lo [2];
	longint            range_hi [2];
	longint unsigned   inv_q16 [2];
	bit                rows_on_y;

	grid_op_t     op_queue[$];
	grid_result_t pending_answers[$];
	logic [31:0]  hot_x [16];
	logic [31:0]  hot_y [16];

	int  items_queued = 0;
	int  items_taken = 0;
	int  results_seen = 0;
	int  err_cnt = 0;
	int  quiet_cycles = 0;
	int  gap_left = 0;
	int  hold_left = 5;
	bit  in_calm = 1'b0;
	bit  out_calm = 1'b0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;

	grid_occupancy_bitmap_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.span_major(span_major),
		.span_min(span_min),
		.span_max(span_max),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bit_value(bit_value),
		.inside_res(inside_res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit in_range(bit axis, longint p);
		return p >= range_lo[axis] && p < range_hi[axis];
	endfunction

	function automatic longint unsigned cell_of(bit axis, longint p);
		longint diff;
		longint unsigned d;
		diff = p - range_lo[axis];
		if (diff < 0)
			return 0;
		d = diff;
		return (d * inv_q16[axis]) >> 24;
	endfunction

	function automatic grid_result_t apply_to_map(grid_op_t op);
		grid_result_t res;
		longint p[2];
		longint p_major;
		longint unsigned row, col, lo_c, hi_c, w;
		logic [63:0] mask;
		bit ma, mi;
		int idx, a, b;
		res = '0;
		ma = rows_on_y;
		mi = ~rows_on_y;
		p[0] = $signed(op.px);
		p[1] = $signed(op.py);
		case (op.cmd)
			gob_pkg::CMD_CHECK, gob_pkg::CMD_SET_POINT, gob_pkg::CMD_CLEAR_POINT: begin
				row = cell_of(ma, p[ma]);
				col = cell_of(mi, p[mi]);
				if (in_range(0, p[0]) && in_range(1, p[1]) && row < gob_pkg::ROWS
					&& col < gob_pkg::NCELLS) begin
					idx = int'(row) * gob_pkg::WORDS_PER_ROW + int'(col >> 6);
					res.ins = 1'b1;
					if (op.cmd == gob_pkg::CMD_CHECK)
						res.bv = occupancy[idx][col[5:0]];
					else if (op.cmd == gob_pkg::CMD_SET_POINT)
						occupancy[idx][col[5:0]] = 1'b1;
					else
						occupancy[idx][col[5:0]] = 1'b0;
				end
			end
			gob_pkg::CMD_SET_SPAN, gob_pkg::CMD_CLEAR_SPAN: begin
				p_major = $signed(op.span_at);
				row = cell_of(ma, p_major);
				if (in_range(ma, p_major) && row < gob_pkg::ROWS) begin
					res.ins = 1'b1;
					lo_c = cell_of(mi, $signed(op.span_from));
					hi_c = cell_of(mi, $signed(op.span_to));
					if (lo_c > gob_pkg::NCELLS - 1)
						lo_c = gob_pkg::NCELLS - 1;
					if (hi_c > gob_pkg::NCELLS - 1)
						hi_c = gob_pkg::NCELLS - 1;
					if (lo_c <= hi_c) begin
						for (w = lo_c >> 6; w <= (hi_c >> 6); w++) begin
							a = (w == (lo_c >> 6)) ? int'(lo_c[5:0]) : 0;
							b = (w == (hi_c >> 6)) ? int'(hi_c[5:0]) : 63;
							mask = ({64{1'b1}} << a) & ({64{1'b1}} >> (63 - b));
							idx = int'(row) * gob_pkg::WORDS_PER_ROW + int'(w);
							if (op.cmd == gob_pkg::CMD_SET_SPAN)
								occupancy[idx] = occupancy[idx] | mask;
							else
								occupancy[idx] = occupancy[idx] & ~mask;
						end
					end
				end
			end
			gob_pkg::CMD_CLEAR_ALL: begin
				foreach (occupancy[i])
					occupancy[i] = '0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = ~calm;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic void note_error(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endfunction

	// A coordinate on one axis: mostly inside the grid, sometimes at a bound or anywhere.
	function automatic logic [31:0] rand_coord(bit axis);
		longint lo, hi, w;
		lo = range_lo[axis];
		hi = range_hi[axis];
		w = hi - lo;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'(lo - 1);
					1: return 32'(lo);
					2: return 32'(hi - 1);
					default: return 32'(hi);
				endcase
			end
			2: return 32'(lo + $urandom_range(0, 2000));
			default: begin
				if (w > 0)
					return 32'(lo + ({$urandom, $urandom} % w));
				return $urandom;
			end
		endcase
	endfunction

	task automatic push_point(logic [2:0] cmd, logic [31:0] x, logic [31:0] y);
		grid_op_t op;
		op.cmd = cmd;
		op.px = x;
		op.py = y;
		op.span_at = $urandom;
		op.span_from = $urandom;
		op.span_to = $urandom;
		op_queue.push_back(op);
		items_queued++;
	endtask

	task automatic push_span(logic [2:0] cmd, logic [31:0] at, logic [31:0] lo,
			logic [31:0] hi);
		grid_op_t op;
		op.cmd = cmd;
		op.px = $urandom;
		op.py = $urandom;
		op.span_at = at;
		op.span_from = lo;
		op.span_to = hi;
		op_queue.push_back(op);
		items_queued++;
	endtask

	task automatic refill_hot();
		foreach (hot_x[i]) begin
			hot_x[i] = rand_coord(0);
			hot_y[i] = rand_coord(1);
		end
	endtask

	// Most point and span items reuse coordinates from a small set of points so that checks find bits set earlier.
	task automatic random_item();
		int r, k;
		logic [31:0] x, y, at, lo, hi, sw;
		bit ma;
		r = $urandom_range(0, 199);
		k = $urandom_range(0, 15);
		ma = rows_on_y;
		if (r < 125) begin
			if ($urandom_range(0, 9) < 6) begin
				x = hot_x[k];
				y = hot_y[k];
			end else begin
				x = rand_coord(0);
				y = rand_coord(1);
				if ($urandom_range(0, 3) == 0) begin
					hot_x[k] = x;
					hot_y[k] = y;
				end
			end
			push_point(r < 60 ? gob_pkg::CMD_CHECK
				: (r < 100 ? gob_pkg::CMD_SET_POINT : gob_pkg::CMD_CLEAR_POINT), x, y);
		end else if (r < 190) begin
			if ($urandom_range(0, 9) < 6)
				at = ma ? hot_y[k] : hot_x[k];
			else
				at = rand_coord(ma);
			lo = rand_coord(~ma);
			hi = rand_coord(~ma);
			if ($urandom_range(0, 4) != 0 && $signed(lo) > $signed(hi)) begin
				sw = lo;
				lo = hi;
				hi = sw;
			end
			push_span(r < 160 ? gob_pkg::CMD_SET_SPAN : gob_pkg::CMD_CLEAR_SPAN, at, lo, hi);
		end else if (r < 197) begin
			push_point(r[0] ? CMD_UNUSED_A : CMD_UNUSED_B, $urandom, $urandom);
		end else begin
			push_point(gob_pkg::CMD_CLEAR_ALL, $urandom, $urandom);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			gob_pkg::REG_RANGE_MIN_X: range_lo[0] = $signed(val);
			gob_pkg::REG_RANGE_MIN_Y: range_lo[1] = $signed(val);
			gob_pkg::REG_RANGE_MAX_X: range_hi[0] = $signed(val);
			gob_pkg::REG_RANGE_MAX_Y: range_hi[1] = $signed(val);
			gob_pkg::REG_INVERSE_CELL_X: inv_q16[0] = val[23:0];
			gob_pkg::REG_INVERSE_CELL_Y: inv_q16[1] = val[23:0];
			gob_pkg::REG_MAJOR_AXIS: rows_on_y = val[0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || pending_answers.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_grid(longint lo_x, longint hi_x, longint lo_y, longint hi_y,
			logic [23:0] ix, logic [23:0] iy, bit axis);
		write_reg(gob_pkg::REG_RANGE_MIN_X, 32'(lo_x));
		write_reg(gob_pkg::REG_RANGE_MAX_X, 32'(hi_x));
		write_reg(gob_pkg::REG_RANGE_MIN_Y, 32'(lo_y));
		write_reg(gob_pkg::REG_RANGE_MAX_Y, 32'(hi_y));
		write_reg(gob_pkg::REG_INVERSE_CELL_X, {8'd0, ix});
		write_reg(gob_pkg::REG_INVERSE_CELL_Y, {8'd0, iy});
		write_reg(gob_pkg::REG_MAJOR_AXIS, {31'd0, axis});
	endtask

	task automatic random_grid();
		longint lo[2], w[2];
		logic [23:0] inv[2];
		int ax;
		for (ax = 0; ax < 2; ax++) begin
			lo[ax] = longint'($urandom_range(0, 2097152)) - 1048576;
			if ($urandom_range(0, 9) == 0)
				w[ax] = -longint'($urandom_range(1, 5000));
			else
				w[ax] = longint'($urandom_range(256, 262144));
			case ($urandom_range(0, 3))
				0: inv[ax] = 24'(65536 * $urandom_range(1, 8));
				1: inv[ax] = 24'($urandom_range(1, 24'hFFFFFF));
				2: inv[ax] = 24'($urandom_range(20000, 200000));
				default: inv[ax] = 24'($urandom_range(1, 4096));
			endcase
		end
		write_grid(lo[0], lo[0] + w[0], lo[1], lo[1] + w[1], inv[0], inv[1],
			1'($urandom_range(0, 1)));
	endtask

	always @(negedge clk) begin : drive_items
		grid_op_t nxt;
		logic drive_v;
		if (arst_n && !(in_valid && !in_taken)) begin
			drive_v = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (op_queue.size() > 0) begin
				nxt = op_queue.pop_front();
				command <= nxt.cmd;
				pos_x <= nxt.px;
				pos_y <= nxt.py;
				span_major <= nxt.span_at;
				span_min <= nxt.span_from;
				span_max <= nxt.span_to;
				drive_v = 1'b1;
				gap_left = draw_wait(in_calm);
			end
			in_valid <= drive_v;
		end
	end

	always @(negedge clk) begin : drive_out_stall
		if (out_taken)
			hold_left = draw_wait(out_calm);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_outputs
		grid_result_t want;
		grid_op_t seen;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_answers.size() == 0) begin
					note_error($sformatf("result %0d arrived with no item waiting",
						results_seen));
				end else begin
					want = pending_answers.pop_front();
					if (bit_value !== want.bv || inside_res !== want.ins)
						note_error($sformatf(
							"result %0d: bit_value exp %0b got %0b, inside_res exp %0b got %0b",
							results_seen, want.bv, bit_value, want.ins, inside_res));
				end
			end
			if (in_valid && !in_stall) begin
				seen.cmd = command;
				seen.px = pos_x;
				seen.py = pos_y;
				seen.span_at = span_major;
				seen.span_from = span_min;
				seen.span_to = span_max;
				pending_answers.push_back(apply_to_map(seen));
				items_taken++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("no transfer for %0d cycles", quiet_cycles);
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		int ph, n;
		range_lo[0] = gob_pkg::RST_RANGE_MIN;
		range_lo[1] = gob_pkg::RST_RANGE_MIN;
		range_hi[0] = gob_pkg::RST_RANGE_MAX;
		range_hi[1] = gob_pkg::RST_RANGE_MAX;
		inv_q16[0] = gob_pkg::RST_INV_CELL;
		inv_q16[1] = gob_pkg::RST_INV_CELL;
		rows_on_y = 1'b0;

		// Default grid: a cell index is the position over 256.
		push_point(gob_pkg::CMD_CHECK, 0, 0);
		push_point(gob_pkg::CMD_SET_POINT, 0, 0);
		push_point(gob_pkg::CMD_CHECK, 0, 0);
		push_point(gob_pkg::CMD_SET_POINT, 131071, 131071);
		push_point(gob_pkg::CMD_CHECK, 131071, 131071);
		push_point(gob_pkg::CMD_CHECK, 131072, 5);
		push_point(gob_pkg::CMD_SET_POINT, -1, 5);
		push_point(gob_pkg::CMD_CLEAR_POINT, 0, 0);
		push_point(gob_pkg::CMD_CHECK, 0, 0);
		push_point(CMD_UNUSED_A, 100, 100);
		push_point(CMD_UNUSED_B, 200, 200);
		push_span(gob_pkg::CMD_SET_SPAN, 1280, 0, 131071);
		push_point(gob_pkg::CMD_CHECK, 1380, 300 * 256);
		push_span(gob_pkg::CMD_CLEAR_SPAN, 1280, 60 * 256, 130 * 256);
		push_point(gob_pkg::CMD_CHECK, 1280, 61 * 256);
		push_point(gob_pkg::CMD_CHECK, 1280, 59 * 256);
		push_span(gob_pkg::CMD_SET_SPAN, 7 * 256, 200 * 256, 100 * 256);
		push_span(gob_pkg::CMD_SET_SPAN, 7 * 256, 32'h8000_0000, 32'h7FFF_FFFF);
		push_point(gob_pkg::CMD_CHECK, 7 * 256, 511 * 256);
		push_span(gob_pkg::CMD_SET_SPAN, 131072, 0, 1000);
		push_span(gob_pkg::CMD_CLEAR_SPAN, 32'h8000_0000, 0, 131071);
		push_point(gob_pkg::CMD_CLEAR_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_point(gob_pkg::CMD_CHECK, 1281, 300 * 256);
		push_point(gob_pkg::CMD_SET_POINT, 32'h7FFF_FFFF, 32'h8000_0000);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < 7; ph++) begin
			wait_idle();
			n = 200;
			case (ph)
				1: write_grid(-5000, 45000, -3000, 97000, 200000, 98304, 1'b1);
				2: begin
					write_grid(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
						24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
					n = 150;
				end
				3: begin
					write_grid(1000, 32'sh7FFF_FFFF, -1000, 32'sh7FFF_FFFF, 1, 1, 1'b1);
					n = 150;
				end
				4: begin
					// A zero cell size factor maps every position to cell zero.
					write_grid(0, 1000, 0, 1000, 0, 0, 1'b0);
					n = 40;
				end
				5, 6: random_grid();
				default: begin
				end
			endcase
			refill_hot();
			repeat (n) random_item();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
sv/gob_pkg.sv
sv/gob_cell_unit.sv
sv/grid_occupancy_bitmap_core.sv
test/tb.sv
